>>> design/cmm_pkg.sv
// cmm_pkg: shared types and constants of the complex matrix multiply core
// command codes, sequencer states, field widths and register indexes
// no dependencies
package cmm_pkg;

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 40;
  localparam int IDX_W     = 4;
  localparam int DIM_REG_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

>>> design/complex_matrix_multiply_core.sv
// complex_matrix_multiply_core: A and B element stores, one shared complex
// multiply-accumulate unit and the sequencer that steps it over the inner dimension
// depends on cmm_pkg
//
// load transaction: written at the accept edge; loads may follow back to back
// compute transaction: one complex mac per cycle over the inner dimension, behind the
//   registered store read and the registered product stage; the result strobe follows
//   once the last product is added, and the next start is taken when idle again
// index error or empty inner dimension: result strobe in the cycle after the accept edge
// reset (synchronous, active low) idles the sequencer and sets all sizes to 16; store
//   contents are not cleared; the receiver cannot stall, each result shows for one cycle
module complex_matrix_multiply_core #(
  parameter int MAX_DIM = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_command,
  input  logic [cmm_pkg::IDX_W-1:0]         in_row,
  input  logic [cmm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [cmm_pkg::ELEM_W-1:0] in_elem_real,
  input  logic signed [cmm_pkg::ELEM_W-1:0] in_elem_imag,
  input  logic                              cfg_we,
  input  logic [cmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cmm_pkg::DIM_REG_W-1:0]     cfg_wdata,
  output logic                              out_valid,
  output logic [cmm_pkg::IDX_W-1:0]         out_row,
  output logic [cmm_pkg::IDX_W-1:0]         out_col,
  output logic signed [cmm_pkg::ACC_W-1:0]  out_sum_real,
  output logic signed [cmm_pkg::ACC_W-1:0]  out_sum_imag,
  output logic                              out_status
);

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CW     = (CNT_W > cmm_pkg::DIM_REG_W) ? CNT_W : cmm_pkg::DIM_REG_W;
  localparam int EW     = cmm_pkg::ELEM_W;
  localparam int PW     = cmm_pkg::PROD_W;
  localparam int AW     = cmm_pkg::ACC_W;

  // configuration
  logic [cmm_pkg::DIM_REG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;

  // sequencer
  cmm_pkg::state_t   state_r, state_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;
  logic              rd_vld_r, prod_vld_r;
  logic              issue;

  // transaction context
  logic [cmm_pkg::IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic                      status_r, status_nxt;

  // stores and datapath
  logic [2*EW-1:0]     mem_a [DEPTH];
  logic [2*EW-1:0]     mem_b [DEPTH];
  logic [2*EW-1:0]     a_rd_r, b_rd_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [AW-1:0] acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;

  logic [CW-1:0]     nr_c, nk_c, nc_c;
  logic              accept, load_ok, idx_err, last_k;
  cmm_pkg::cmd_t     cmd;
  logic [31:0]       wr_addr_w, a_addr_w, b_addr_w;
  logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;
  logic              we_a, we_b;

  assign accept = start && (state_r == cmm_pkg::ST_IDLE);
  assign cmd    = cmm_pkg::cmd_t'(in_command);

  // sizes above the store act as the store size
  assign nr_c = (CW'(rows_a_r) > CW'(MAX_DIM))    ? CW'(MAX_DIM) : CW'(rows_a_r);
  assign nk_c = (CW'(inner_dim_r) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(inner_dim_r);
  assign nc_c = (CW'(cols_b_r) > CW'(MAX_DIM))    ? CW'(MAX_DIM) : CW'(cols_b_r);

  assign idx_err = (CW'(in_row) >= nr_c) || (CW'(in_col) >= nc_c);
  assign last_k  = (CW'(k_r) == nk_c - CW'(1));
  assign load_ok = (32'(in_row) < 32'(MAX_DIM)) && (32'(in_col) < 32'(MAX_DIM));

  assign wr_addr_w = 32'(in_row) * 32'(MAX_DIM) + 32'(in_col);
  assign a_addr_w  = 32'(row_r) * 32'(MAX_DIM) + 32'(k_r);
  assign b_addr_w  = 32'(k_r) * 32'(MAX_DIM) + 32'(col_r);
  assign wr_addr   = wr_addr_w[ADDR_W-1:0];
  assign a_addr    = a_addr_w[ADDR_W-1:0];
  assign b_addr    = b_addr_w[ADDR_W-1:0];

  assign we_a = accept && (cmd == cmm_pkg::CMD_LOAD_A) && load_ok;
  assign we_b = accept && (cmd == cmm_pkg::CMD_LOAD_B) && load_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= cmm_pkg::DIM_RESET;
      inner_dim_r <= cmm_pkg::DIM_RESET;
      cols_b_r    <= cmm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cmm_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_wdata;
        cmm_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_wdata;
        cmm_pkg::CFG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // element stores, real part in the high half
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= {in_elem_real, in_elem_imag};
    end
    a_rd_r <= mem_a[a_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= {in_elem_real, in_elem_imag};
    end
    b_rd_r <= mem_b[b_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cmm_pkg::ST_IDLE: begin
        if (accept && (cmd == cmm_pkg::CMD_COMPUTE)) begin
          if (idx_err || (nk_c == '0)) begin
            state_nxt = cmm_pkg::ST_DONE;
          end else begin
            state_nxt = cmm_pkg::ST_RUN;
          end
        end
      end
      cmm_pkg::ST_RUN: begin
        if (last_k) begin
          state_nxt = cmm_pkg::ST_DRAIN;
        end
      end
      cmm_pkg::ST_DRAIN: begin
        // last product is added at this edge
        if (prod_vld_r && !rd_vld_r) begin
          state_nxt = cmm_pkg::ST_DONE;
        end
      end
      cmm_pkg::ST_DONE: state_nxt = cmm_pkg::ST_IDLE;
      default:          state_nxt = cmm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    busy      = (state_r != cmm_pkg::ST_IDLE);
    out_valid = (state_r == cmm_pkg::ST_DONE);
    issue     = (state_r == cmm_pkg::ST_RUN);
  end

  always_comb begin
    k_nxt      = k_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    status_nxt = status_r;
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (accept && (cmd == cmm_pkg::CMD_COMPUTE)) begin
      k_nxt      = '0;
      row_nxt    = in_row;
      col_nxt    = in_col;
      status_nxt = idx_err ? cmm_pkg::STATUS_RANGE : cmm_pkg::STATUS_OK;
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else begin
      if (issue) begin
        k_nxt = k_r + DIM_W'(1);
      end
      if (prod_vld_r) begin
        acc_re_nxt = acc_re_r + AW'(p_rr_r) - AW'(p_ii_r);
        acc_im_nxt = acc_im_r + AW'(p_ri_r) + AW'(p_ir_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cmm_pkg::ST_IDLE;
      k_r        <= '0;
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      rd_vld_r   <= issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  // shared complex multiply stage
  always_ff @(posedge clk) begin
    p_rr_r <= $signed(a_rd_r[2*EW-1:EW]) * $signed(b_rd_r[2*EW-1:EW]);
    p_ii_r <= $signed(a_rd_r[EW-1:0])    * $signed(b_rd_r[EW-1:0]);
    p_ri_r <= $signed(a_rd_r[2*EW-1:EW]) * $signed(b_rd_r[EW-1:0]);
    p_ir_r <= $signed(a_rd_r[EW-1:0])    * $signed(b_rd_r[2*EW-1:EW]);
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    status_r <= status_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
  end

  assign out_row      = row_r;
  assign out_col      = col_r;
  assign out_sum_real = acc_re_r;
  assign out_sum_imag = acc_im_r;
  assign out_status   = status_r;

endmodule
